FILE: hw/rtl/qrs_pkg.sv
// Package for the quadratic root solver: widths, status codes and the
// records that travel down the square-root and divider cell rows.
// No dependencies.
package qrs_pkg;

    // coefficient width (two's complement, 8 fractional bits)
    localparam int CW = 16;
    // Q8.8 in, Q16.16 out, divided by 2a: quotient scale is 2^15
    localparam int FRAC_SHIFT = 15;
    // root width and remainder width (radicand always below 2^(2*CW+1))
    localparam int SW = CW + 1;
    localparam int RW = SW + 2;
    // discriminant width, signed
    localparam int DSW = 2 * CW + 3;
    // numerator -b +/- s, signed, and its magnitude
    localparam int NW = CW + 3;
    localparam int MW = CW + 2;
    // dividend / quotient width
    localparam int QW = MW + FRAC_SHIFT;
    localparam int OW = 32;

    localparam logic [1:0] ST_TWO    = 2'd0;
    localparam logic [1:0] ST_REPEAT = 2'd1;
    localparam logic [1:0] ST_NONE   = 2'd2;
    localparam logic [1:0] ST_AZERO  = 2'd3;

    // per-equation data riding along the square-root row
    typedef struct packed {
        logic                a_neg;
        logic [CW-1:0]       a_mag;
        logic signed [CW:0]  nb;
        logic [1:0]          status;
    } t_side;

    // one square-root cell's state
    typedef struct packed {
        t_side               side;
        logic [2*SW-1:0]     rad;
        logic [RW-1:0]       rem;
        logic [SW-1:0]       root;
    } t_sq;

    // one divider cell's state, both roots side by side
    typedef struct packed {
        logic [1:0]          status;
        logic [CW-1:0]       a_mag;
        logic                neg_p;
        logic                neg_m;
        logic [CW-1:0]       rem_p;
        logic [CW-1:0]       rem_m;
        logic [QW-1:0]       n_p;
        logic [QW-1:0]       n_m;
    } t_dv;

endpackage

FILE: hw/rtl/qrs_coef_if.sv
// Coefficient channel: valid/ready handshake with a, b and c.
// Depends on qrs_pkg.
interface qrs_coef_if;
    logic                          valid;
    logic                          ready;
    logic signed [qrs_pkg::CW-1:0] coef_a;
    logic signed [qrs_pkg::CW-1:0] coef_b;
    logic signed [qrs_pkg::CW-1:0] coef_c;

    modport source (output valid, coef_a, coef_b, coef_c, input ready);
    modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

FILE: hw/rtl/qrs_root_if.sv
// Result channel: valid/ready handshake with both roots, status and clip flag.
// Depends on qrs_pkg.
interface qrs_root_if;
    logic                          valid;
    logic                          ready;
    logic signed [qrs_pkg::OW-1:0] root_plus;
    logic signed [qrs_pkg::OW-1:0] root_minus;
    logic [1:0]                    root_status;
    logic                          saturated;

    modport source (output valid, root_plus, root_minus, root_status, saturated,
                    input ready);
    modport sink (input valid, root_plus, root_minus, root_status, saturated,
                  output ready);
endinterface

FILE: hw/rtl/quadratic_root_solver.sv
// Quadratic root solver. Takes one set of Q8.8 coefficients per cycle while
// the output is not stalled and returns both real roots in saturated Q16.16
// with a status, in order. The pipeline is a product stage, a discriminant
// stage, CW+1 square-root cells, one numerator stage, CW+17 divider
// cells and the output register. Each cell stage holds its beat until the next
// frees up, so bubbles close and a stalled output only stops what is behind it.
// Depends on qrs_pkg, qrs_coef_if, qrs_root_if, qrs_sqrt_cell, qrs_div_cell.
module quadratic_root_solver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qrs_coef_if.sink   i_coef,
    qrs_root_if.source o_root
);
    localparam int CW  = qrs_pkg::CW;
    localparam int SW  = qrs_pkg::SW;
    localparam int QW  = qrs_pkg::QW;
    localparam int DSW = qrs_pkg::DSW;
    localparam int NW  = qrs_pkg::NW;
    localparam int MW  = qrs_pkg::MW;
    localparam int OW  = qrs_pkg::OW;

    // ---- stage 1: products ----
    logic                   r_s1_vld;
    logic signed [CW-1:0]   r_s1_a;
    logic signed [CW-1:0]   r_s1_b;
    logic signed [2*CW-1:0] r_s1_bb;
    logic signed [2*CW-1:0] r_s1_ac;
    logic                   rdy1;
    logic                   rdy2;

    assign rdy1 = !r_s1_vld || rdy2;
    assign i_coef.ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (rdy1) begin
            r_s1_vld <= i_coef.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_a  <= i_coef.coef_a;
            r_s1_b  <= i_coef.coef_b;
            r_s1_bb <= i_coef.coef_b * i_coef.coef_b;
            r_s1_ac <= i_coef.coef_a * i_coef.coef_c;
        end
    end

    // ---- stage 2: discriminant and status ----
    logic                  r_s2_vld;
    qrs_pkg::t_sq          r_s2;
    qrs_pkg::t_sq          n_s2;
    logic signed [DSW-1:0] disc;
    logic [CW-1:0]         a_mag;
    logic [SW:0]           sq_rdy;
    logic [SW:0]           sq_vld;
    qrs_pkg::t_sq          sq_dat [SW+1];

    assign rdy2 = !r_s2_vld || sq_rdy[0];

    always_comb begin
        disc  = {{3{r_s1_bb[2*CW-1]}}, r_s1_bb} - {r_s1_ac[2*CW-1], r_s1_ac, 2'b00};
        a_mag = r_s1_a[CW-1] ? CW'(-r_s1_a) : CW'(r_s1_a);
        n_s2.side.a_neg = r_s1_a[CW-1];
        n_s2.side.a_mag = a_mag;
        n_s2.side.nb    = -{r_s1_b[CW-1], r_s1_b};
        if (r_s1_a == '0) begin
            n_s2.side.status = qrs_pkg::ST_AZERO;
        end else if (disc[DSW-1]) begin
            n_s2.side.status = qrs_pkg::ST_NONE;
        end else if (disc == '0) begin
            n_s2.side.status = qrs_pkg::ST_REPEAT;
        end else begin
            n_s2.side.status = qrs_pkg::ST_TWO;
        end
        n_s2.rad  = disc[2*SW-1:0];
        n_s2.rem  = '0;
        n_s2.root = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (rdy2) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_s2 <= n_s2;
        end
    end

    // ---- square-root row ----
    logic rdy3;

    assign sq_vld[0] = r_s2_vld;
    assign sq_dat[0] = r_s2;
    assign sq_rdy[SW] = rdy3;

    for (genvar k = 0; k < SW; k++) begin : g_sq
        qrs_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (sq_vld[k]),
            .i_data  (sq_dat[k]),
            .o_rdy   (sq_rdy[k]),
            .o_vld   (sq_vld[k+1]),
            .o_data  (sq_dat[k+1]),
            .i_rdy   (sq_rdy[k+1])
        );
    end

    // ---- stage 3: numerators -b +/- s as sign and magnitude ----
    logic                 r_s3_vld;
    qrs_pkg::t_dv         r_s3;
    qrs_pkg::t_dv         n_s3;
    qrs_pkg::t_sq         sq_end;
    logic signed [NW-1:0] num_p;
    logic signed [NW-1:0] num_m;
    logic signed [NW-1:0] nb_x;
    logic signed [NW-1:0] s_x;
    logic [MW-1:0]        mag_p;
    logic [MW-1:0]        mag_m;
    logic [QW:0]          dv_rdy;
    logic [QW:0]          dv_vld;
    qrs_pkg::t_dv         dv_dat [QW+1];

    assign sq_end = sq_dat[SW];
    assign rdy3   = !r_s3_vld || dv_rdy[0];

    always_comb begin
        nb_x  = NW'(sq_end.side.nb);
        s_x   = NW'({1'b0, sq_end.root});
        num_p = nb_x + s_x;
        num_m = nb_x - s_x;
        mag_p = num_p[NW-1] ? MW'(-num_p) : MW'(num_p);
        mag_m = num_m[NW-1] ? MW'(-num_m) : MW'(num_m);
        n_s3.status = sq_end.side.status;
        n_s3.a_mag  = sq_end.side.a_mag;
        n_s3.neg_p  = num_p[NW-1] ^ sq_end.side.a_neg;
        n_s3.neg_m  = num_m[NW-1] ^ sq_end.side.a_neg;
        n_s3.rem_p  = '0;
        n_s3.rem_m  = '0;
        n_s3.n_p    = {mag_p, {qrs_pkg::FRAC_SHIFT{1'b0}}};
        n_s3.n_m    = {mag_m, {qrs_pkg::FRAC_SHIFT{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (rdy3) begin
            r_s3_vld <= sq_vld[SW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_s3 <= n_s3;
        end
    end

    // ---- divider row ----
    logic rdy_o;

    assign dv_vld[0] = r_s3_vld;
    assign dv_dat[0] = r_s3;
    assign dv_rdy[QW] = rdy_o;

    for (genvar k = 0; k < QW; k++) begin : g_dv
        qrs_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (dv_vld[k]),
            .i_data  (dv_dat[k]),
            .o_rdy   (dv_rdy[k]),
            .o_vld   (dv_vld[k+1]),
            .o_data  (dv_dat[k+1]),
            .i_rdy   (dv_rdy[k+1])
        );
    end

    // ---- output register: sign, clip, mask ----
    logic          r_o_vld;
    logic [OW-1:0] r_o_p;
    logic [OW-1:0] r_o_m;
    logic [1:0]    r_o_st;
    logic          r_o_sat;
    qrs_pkg::t_dv  dv_end;
    logic [63:0]   qx_p;
    logic [63:0]   qx_m;
    logic [OW-1:0] v_p;
    logic [OW-1:0] v_m;
    logic          sat_p;
    logic          sat_m;
    logic          real_rt;

    assign dv_end = dv_dat[QW];
    assign rdy_o  = !r_o_vld || o_root.ready;

    always_comb begin
        qx_p = 64'(dv_end.n_p);
        qx_m = 64'(dv_end.n_m);
        sat_p = 1'b0;
        sat_m = 1'b0;
        if (dv_end.neg_p) begin
            if (qx_p > 64'h8000_0000) begin
                sat_p = 1'b1;
                v_p   = 32'h8000_0000;
            end else begin
                v_p   = OW'(-qx_p);
            end
        end else if (qx_p > 64'h7FFF_FFFF) begin
            sat_p = 1'b1;
            v_p   = 32'h7FFF_FFFF;
        end else begin
            v_p   = OW'(qx_p);
        end
        if (dv_end.neg_m) begin
            if (qx_m > 64'h8000_0000) begin
                sat_m = 1'b1;
                v_m   = 32'h8000_0000;
            end else begin
                v_m   = OW'(-qx_m);
            end
        end else if (qx_m > 64'h7FFF_FFFF) begin
            sat_m = 1'b1;
            v_m   = 32'h7FFF_FFFF;
        end else begin
            v_m   = OW'(qx_m);
        end
        real_rt = (dv_end.status == qrs_pkg::ST_TWO)
               || (dv_end.status == qrs_pkg::ST_REPEAT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (rdy_o) begin
            r_o_vld <= dv_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_o) begin
            r_o_st  <= dv_end.status;
            r_o_p   <= real_rt ? v_p : '0;
            r_o_m   <= real_rt ? v_m : '0;
            r_o_sat <= real_rt && (sat_p || sat_m);
        end
    end

    assign o_root.valid       = r_o_vld;
    assign o_root.root_plus   = r_o_p;
    assign o_root.root_minus  = r_o_m;
    assign o_root.root_status = r_o_st;
    assign o_root.saturated   = r_o_sat;
endmodule

FILE: hw/rtl/qrs_sqrt_cell.sv
// One cell of the square-root row: resolves one root bit per beat.
// Depends on qrs_pkg.
module qrs_sqrt_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  qrs_pkg::t_sq  i_data,
    output logic          o_rdy,
    output logic          o_vld,
    output qrs_pkg::t_sq  o_data,
    input  logic          i_rdy
);
    logic                       r_vld;
    qrs_pkg::t_sq               r_data;
    qrs_pkg::t_sq               n_data;
    logic [qrs_pkg::RW-1:0]     rem_sh;
    logic [qrs_pkg::RW-1:0]     trial;

    assign o_rdy = !r_vld || i_rdy;

    // bring down two radicand bits, try root*4+1
    always_comb begin
        rem_sh = {i_data.rem[qrs_pkg::RW-3:0],
                  i_data.rad[2*qrs_pkg::SW-1 -: 2]};
        trial  = {i_data.root, 2'b01};
        n_data = i_data;
        n_data.rad = {i_data.rad[2*qrs_pkg::SW-3:0], 2'b00};
        if (rem_sh >= trial) begin
            n_data.rem  = rem_sh - trial;
            n_data.root = {i_data.root[qrs_pkg::SW-2:0], 1'b1};
        end else begin
            n_data.rem  = rem_sh;
            n_data.root = {i_data.root[qrs_pkg::SW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;
endmodule

FILE: hw/rtl/qrs_div_cell.sv
// One cell of the divider row: one quotient bit per beat for both roots.
// Depends on qrs_pkg.
module qrs_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  qrs_pkg::t_dv  i_data,
    output logic          o_rdy,
    output logic          o_vld,
    output qrs_pkg::t_dv  o_data,
    input  logic          i_rdy
);
    logic                   r_vld;
    qrs_pkg::t_dv           r_data;
    qrs_pkg::t_dv           n_data;
    logic [qrs_pkg::CW:0]   sh_p;
    logic [qrs_pkg::CW:0]   sh_m;
    logic [qrs_pkg::CW:0]   dvs;
    logic [qrs_pkg::CW:0]   df_p;
    logic [qrs_pkg::CW:0]   df_m;

    assign o_rdy = !r_vld || i_rdy;

    // restoring step: shift in next dividend bit, subtract |a| if it fits
    always_comb begin
        dvs   = {1'b0, i_data.a_mag};
        sh_p  = {i_data.rem_p, i_data.n_p[qrs_pkg::QW-1]};
        sh_m  = {i_data.rem_m, i_data.n_m[qrs_pkg::QW-1]};
        df_p  = sh_p - dvs;
        df_m  = sh_m - dvs;
        n_data = i_data;
        if (sh_p >= dvs) begin
            n_data.rem_p = df_p[qrs_pkg::CW-1:0];
            n_data.n_p   = {i_data.n_p[qrs_pkg::QW-2:0], 1'b1};
        end else begin
            n_data.rem_p = sh_p[qrs_pkg::CW-1:0];
            n_data.n_p   = {i_data.n_p[qrs_pkg::QW-2:0], 1'b0};
        end
        if (sh_m >= dvs) begin
            n_data.rem_m = df_m[qrs_pkg::CW-1:0];
            n_data.n_m   = {i_data.n_m[qrs_pkg::QW-2:0], 1'b1};
        end else begin
            n_data.rem_m = sh_m[qrs_pkg::CW-1:0];
            n_data.n_m   = {i_data.n_m[qrs_pkg::QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;
endmodule
